[hw/rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the connection handshake table.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int PendDepth = 8;
   localparam int AccDepth  = 8;
   localparam int PendIdxW  = (PendDepth > 1) ? $clog2(PendDepth) : 1;
   localparam int AccIdxW   = (AccDepth > 1) ? $clog2(AccDepth) : 1;

   localparam logic [1:0] OP_SYN    = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_ACCEPT = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [3:0] ST_NEW_SYNACK  = 4'd0;
   localparam logic [3:0] ST_RESEND      = 4'd1;
   localparam logic [3:0] ST_SYN_DROPPED = 4'd2;
   localparam logic [3:0] ST_ESTAB       = 4'd3;
   localparam logic [3:0] ST_ALREADY     = 4'd4;
   localparam logic [3:0] ST_ACC_FULL    = 4'd5;
   localparam logic [3:0] ST_NO_PEND     = 4'd6;
   localparam logic [3:0] ST_POPPED      = 4'd7;
   localparam logic [3:0] ST_EMPTY       = 4'd8;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [15:0] conn_handle;
      logic [15:0] local_port;
      logic [31:0] seq_in;
      logic [31:0] ack_in;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  slot;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic [15:0] reply_port;
      logic [31:0] out_ip;
      logic [15:0] out_port;
      logic [15:0] out_handle;
      logic [31:0] client_seq;
      logic [31:0] client_ack;
   } rsp_type;

endpackage

[hw/rtl/connection_handshake_table.sv]
// ----------------------------------------------------------------------------
// connection_handshake_table
// Handshake tracker of a listener: half-open and accepted connection tables.
// ----------------------------------------------------------------------------
// Requests enter through push/full with op and packet fields; responses
// leave through empty/pop, one per request with op 0..2 (op 3 is dropped).
// The front holds a two-entry request queue; the engine takes a request,
// searches both eight-entry tables in its look state and updates them and
// the response register in its do state once that register is free; it
// starts no new search until the current response is written, while the
// queue keeps taking requests until it is full.
// While the response waits unpopped the engine holds and the queue fills;
// full rises once two requests wait. csr_valid/csr_ready write initial_seq,
// always ready. Reset (synchronous) empties both tables and the queue and
// clears initial_seq and the last reply.
// ----------------------------------------------------------------------------
module connection_handshake_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_peer_ip,
   input  logic [15:0] req_peer_port,
   input  logic [15:0] req_conn_handle,
   input  logic [15:0] req_local_port,
   input  logic [31:0] req_seq_in,
   input  logic [31:0] req_ack_in,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_status,
   output logic [2:0]  rsp_slot,
   output logic [31:0] rsp_reply_seq,
   output logic [31:0] rsp_reply_ack,
   output logic [15:0] rsp_reply_port,
   output logic [31:0] rsp_out_ip,
   output logic [15:0] rsp_out_port,
   output logic [15:0] rsp_out_handle,
   output logic [31:0] rsp_client_seq,
   output logic [31:0] rsp_client_ack,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_initial_seq
);

   cht_pkg::req_type req, q_req;
   cht_pkg::rsp_type rsp;
   logic             q_valid, q_take;
   logic [31:0]      iseq_ff;

   assign req = '{op: req_op, peer_ip: req_peer_ip, peer_port: req_peer_port,
                  conn_handle: req_conn_handle, local_port: req_local_port,
                  seq_in: req_seq_in, ack_in: req_ack_in};
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iseq_ff <= '0;
      end else if (csr_valid) begin
         iseq_ff <= csr_initial_seq;
      end
   end

   cht_front u_front (
      .clock, .reset, .push, .full, .req_in(req),
      .q_valid, .q_req, .q_take
   );

   cht_engine u_engine (
      .clock, .reset, .initial_seq(iseq_ff), .q_valid, .q_req, .q_take,
      .rsp_empty(empty), .rsp_pop(pop), .rsp
   );

   assign rsp_status     = rsp.status;
   assign rsp_slot       = rsp.slot;
   assign rsp_reply_seq  = rsp.reply_seq;
   assign rsp_reply_ack  = rsp.reply_ack;
   assign rsp_reply_port = rsp.reply_port;
   assign rsp_out_ip     = rsp.out_ip;
   assign rsp_out_port   = rsp.out_port;
   assign rsp_out_handle = rsp.out_handle;
   assign rsp_client_seq = rsp.client_seq;
   assign rsp_client_ack = rsp.client_ack;

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_take |-> $past(1'b1) && q_valid)
      else $error("engine took a request from an empty queue");
   a_fill_after_take: assert property (@(posedge clock) disable iff (reset)
      q_take |=> !empty)
      else $error("response register not filled after a request");
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !q_take)
      else $error("engine advanced over an unpopped response");

endmodule

[hw/rtl/cht_front.sv]
// ----------------------------------------------------------------------------
// cht_front
// Input stage: takes requests, drops unused op codes, and holds a two-entry
// queue towards the table engine.
// ----------------------------------------------------------------------------
module cht_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  cht_pkg::req_type req_in,
   output logic             q_valid,
   output cht_pkg::req_type q_req,
   input  logic             q_take
);

   cht_pkg::req_type mem_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             keep;

   assign full    = (cnt_ff == 2'd2);
   assign keep    = push && !full && (req_in.op != cht_pkg::OP_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_req   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ keep;
      rd_in  = rd_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + {1'b0, keep} - {1'b0, q_take && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (keep) begin
         mem_ff[wr_ff] <= req_in;
      end
   end

endmodule

[hw/rtl/cht_engine.sv]
// ----------------------------------------------------------------------------
// cht_engine
// Table engine: searches the half-open and accepted tables in its look
// state, then updates them and writes the response register in its do state.
// ----------------------------------------------------------------------------
module cht_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic [31:0]      initial_seq,
   input  logic             q_valid,
   input  cht_pkg::req_type q_req,
   output logic             q_take,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cht_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      S_LOOK = 2'b01,
      S_DO   = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [cht_pkg::PendDepth-1:0] pv_ff;
   logic [31:0] pip_ff [cht_pkg::PendDepth];
   logic [15:0] ppt_ff [cht_pkg::PendDepth];
   logic [15:0] phd_ff [cht_pkg::PendDepth];
   logic [cht_pkg::AccDepth-1:0] av_ff;
   logic [31:0] aip_ff [cht_pkg::AccDepth];
   logic [15:0] apt_ff [cht_pkg::AccDepth];
   logic [15:0] ahd_ff [cht_pkg::AccDepth];
   logic [31:0] lack_ff;
   logic [15:0] lport_ff;

   logic                        pm_ff, pf_ff, am_ff, af_ff, av1_ff;
   logic [cht_pkg::PendIdxW-1:0] pmi_ff, pfi_ff;
   logic [cht_pkg::AccIdxW-1:0]  afi_ff, ali_ff;
   logic                        pm, pf, am, af, av1;
   logic [cht_pkg::PendIdxW-1:0] pmi, pfi;
   logic [cht_pkg::AccIdxW-1:0]  afi, ali;

   cht_pkg::rsp_type r_in;
   logic             full_ff;
   logic [31:0]      ack1;

   always_comb begin
      pm = 1'b0; pf = 1'b0; pmi = '0; pfi = '0;
      for (int i = cht_pkg::PendDepth - 1; i >= 0; i--) begin
         if (pv_ff[i] && pip_ff[i] == q_req.peer_ip && ppt_ff[i] == q_req.peer_port) begin
            pm  = 1'b1;
            pmi = cht_pkg::PendIdxW'(i);
         end
         if (!pv_ff[i]) begin
            pf  = 1'b1;
            pfi = cht_pkg::PendIdxW'(i);
         end
      end
      am = 1'b0; af = 1'b0; av1 = 1'b0; afi = '0; ali = '0;
      for (int i = cht_pkg::AccDepth - 1; i >= 0; i--) begin
         if (av_ff[i] && aip_ff[i] == q_req.peer_ip && apt_ff[i] == q_req.peer_port) begin
            am = 1'b1;
         end
         if (!av_ff[i]) begin
            af  = 1'b1;
            afi = cht_pkg::AccIdxW'(i);
         end else begin
            av1 = 1'b1;
            ali = cht_pkg::AccIdxW'(i);
         end
      end
   end

   assign q_take    = (state_ff == S_DO) && !full_ff;
   assign rsp_empty = !full_ff;
   assign ack1      = q_req.seq_in + 32'd1;

   always_comb begin
      r_in = '0;
      case (q_req.op)
         cht_pkg::OP_SYN: begin
            if (pm_ff) begin
               r_in.status     = cht_pkg::ST_RESEND;
               r_in.reply_seq  = initial_seq;
               r_in.reply_ack  = lack_ff;
               r_in.reply_port = lport_ff;
            end else if (pf_ff) begin
               r_in.status     = cht_pkg::ST_NEW_SYNACK;
               r_in.slot       = 3'(pfi_ff);
               r_in.reply_seq  = initial_seq;
               r_in.reply_ack  = ack1;
               r_in.reply_port = q_req.local_port;
            end else begin
               r_in.status = cht_pkg::ST_SYN_DROPPED;
            end
         end
         cht_pkg::OP_ACK: begin
            if (am_ff) begin
               r_in.status = cht_pkg::ST_ALREADY;
            end else if (!af_ff) begin
               r_in.status = cht_pkg::ST_ACC_FULL;
            end else if (!pm_ff) begin
               r_in.status = cht_pkg::ST_NO_PEND;
            end else begin
               r_in.status     = cht_pkg::ST_ESTAB;
               r_in.slot       = 3'(afi_ff);
               r_in.client_seq = q_req.seq_in;
               r_in.client_ack = q_req.ack_in;
            end
         end
         default: begin
            if (av1_ff) begin
               r_in.status     = cht_pkg::ST_POPPED;
               r_in.slot       = 3'(ali_ff);
               r_in.out_ip     = aip_ff[ali_ff];
               r_in.out_port   = apt_ff[ali_ff];
               r_in.out_handle = ahd_ff[ali_ff];
            end else begin
               r_in.status = cht_pkg::ST_EMPTY;
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOOK:  if (q_valid) state_in = S_DO;
         S_DO:    if (!full_ff) state_in = S_LOOK;
         default: state_in = S_LOOK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOOK;
         pv_ff    <= '0;
         av_ff    <= '0;
         lack_ff  <= '0;
         lport_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_pop && full_ff) full_ff <= 1'b0;
         if (q_take) begin
            full_ff <= 1'b1;
            rsp     <= r_in;
            if (q_req.op == cht_pkg::OP_SYN && !pm_ff && pf_ff) begin
               pv_ff[pfi_ff]  <= 1'b1;
               pip_ff[pfi_ff] <= q_req.peer_ip;
               ppt_ff[pfi_ff] <= q_req.peer_port;
               phd_ff[pfi_ff] <= q_req.conn_handle;
               lack_ff        <= ack1;
               lport_ff       <= q_req.local_port;
            end
            if (q_req.op == cht_pkg::OP_ACK && !am_ff && af_ff && pm_ff) begin
               av_ff[afi_ff]  <= 1'b1;
               aip_ff[afi_ff] <= q_req.peer_ip;
               apt_ff[afi_ff] <= q_req.peer_port;
               ahd_ff[afi_ff] <= phd_ff[pmi_ff];
               pv_ff[pmi_ff]  <= 1'b0;
            end
            if (q_req.op == cht_pkg::OP_ACCEPT && av1_ff) begin
               av_ff[ali_ff] <= 1'b0;
            end
         end
      end
      if (state_ff == S_LOOK) begin
         pm_ff <= pm; pf_ff <= pf; pmi_ff <= pmi; pfi_ff <= pfi;
         am_ff <= am; af_ff <= af; afi_ff <= afi; av1_ff <= av1; ali_ff <= ali;
      end
   end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the connection handshake table.
// ----------------------------------------------------------------------------
// Streams SYN, ACK and accept requests, mostly from a bounded pool of peers,
// through the push/full side and checks every response on the empty/pop side
// against a behavioural copy of both tables. initial_seq is rewritten between
// phases while the block is idle; stall rates are set per phase, none in the last.
// ----------------------------------------------------------------------------
module tb_top;

   logic             clock;
   logic             reset;
   logic             push;
   logic             full;
   logic             empty;
   logic             pop;
   logic             csr_valid;
   logic             csr_ready;
   logic [31:0]      csr_initial_seq;
   cht_pkg::req_type drv_req;
   cht_pkg::rsp_type dut_rsp;

   connection_handshake_table u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (drv_req.op),
      .req_peer_ip     (drv_req.peer_ip),
      .req_peer_port   (drv_req.peer_port),
      .req_conn_handle (drv_req.conn_handle),
      .req_local_port  (drv_req.local_port),
      .req_seq_in      (drv_req.seq_in),
      .req_ack_in      (drv_req.ack_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_status      (dut_rsp.status),
      .rsp_slot        (dut_rsp.slot),
      .rsp_reply_seq   (dut_rsp.reply_seq),
      .rsp_reply_ack   (dut_rsp.reply_ack),
      .rsp_reply_port  (dut_rsp.reply_port),
      .rsp_out_ip      (dut_rsp.out_ip),
      .rsp_out_port    (dut_rsp.out_port),
      .rsp_out_handle  (dut_rsp.out_handle),
      .rsp_client_seq  (dut_rsp.client_seq),
      .rsp_client_ack  (dut_rsp.client_ack),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_initial_seq (csr_initial_seq)
   );

   // table model
   logic        mdl_pend_v [cht_pkg::PendDepth];
   logic [31:0] mdl_pend_ip [cht_pkg::PendDepth];
   logic [15:0] mdl_pend_port [cht_pkg::PendDepth];
   logic [15:0] mdl_pend_hdl [cht_pkg::PendDepth];
   logic        mdl_acc_v [cht_pkg::AccDepth];
   logic [31:0] mdl_acc_ip [cht_pkg::AccDepth];
   logic [15:0] mdl_acc_port [cht_pkg::AccDepth];
   logic [15:0] mdl_acc_hdl [cht_pkg::AccDepth];
   logic [31:0] mdl_last_ack;
   logic [15:0] mdl_last_port;
   logic [31:0] mdl_iss;

   cht_pkg::req_type pending_reqs[$];
   cht_pkg::rsp_type expected_rsps[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          errors;
   int          n_req;
   int          n_rsp;
   int          status_seen[9];
   logic [31:0] pool_ip[6];
   logic [15:0] pool_port[6];

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic cht_pkg::rsp_type predict_response(cht_pkg::req_type r);
      cht_pkg::rsp_type o;
      int      hit;
      int      fr;
      int      p;
      o   = '0;
      hit = -1;
      fr  = -1;
      p   = -1;
      if (r.op == cht_pkg::OP_SYN) begin
         for (int i = 0; i < cht_pkg::PendDepth; i++) begin
            if (mdl_pend_v[i]) begin
               if (hit < 0 && mdl_pend_ip[i] == r.peer_ip && mdl_pend_port[i] == r.peer_port)
                  hit = i;
            end else if (fr < 0) begin
               fr = i;
            end
         end
         if (hit >= 0) begin
            o.status     = cht_pkg::ST_RESEND;
            o.reply_seq  = mdl_iss;
            o.reply_ack  = mdl_last_ack;
            o.reply_port = mdl_last_port;
         end else if (fr >= 0) begin
            mdl_pend_v[fr]    = 1'b1;
            mdl_pend_ip[fr]   = r.peer_ip;
            mdl_pend_port[fr] = r.peer_port;
            mdl_pend_hdl[fr]  = r.conn_handle;
            mdl_last_ack      = r.seq_in + 32'd1;
            mdl_last_port     = r.local_port;
            o.status     = cht_pkg::ST_NEW_SYNACK;
            o.slot       = fr[2:0];
            o.reply_seq  = mdl_iss;
            o.reply_ack  = mdl_last_ack;
            o.reply_port = r.local_port;
         end else begin
            o.status = cht_pkg::ST_SYN_DROPPED;
         end
      end else if (r.op == cht_pkg::OP_ACK) begin
         for (int i = 0; i < cht_pkg::AccDepth; i++) begin
            if (mdl_acc_v[i]) begin
               if (hit < 0 && mdl_acc_ip[i] == r.peer_ip && mdl_acc_port[i] == r.peer_port)
                  hit = i;
            end else if (fr < 0) begin
               fr = i;
            end
         end
         if (hit >= 0) begin
            o.status = cht_pkg::ST_ALREADY;
         end else if (fr < 0) begin
            o.status = cht_pkg::ST_ACC_FULL;
         end else begin
            for (int i = cht_pkg::PendDepth - 1; i >= 0; i--)
               if (mdl_pend_v[i] && mdl_pend_ip[i] == r.peer_ip
                   && mdl_pend_port[i] == r.peer_port)
                  p = i;
            if (p < 0) begin
               o.status = cht_pkg::ST_NO_PEND;
            end else begin
               mdl_acc_v[fr]    = 1'b1;
               mdl_acc_ip[fr]   = r.peer_ip;
               mdl_acc_port[fr] = r.peer_port;
               mdl_acc_hdl[fr]  = mdl_pend_hdl[p];
               mdl_pend_v[p]    = 1'b0;
               o.status     = cht_pkg::ST_ESTAB;
               o.slot       = fr[2:0];
               o.client_seq = r.seq_in;
               o.client_ack = r.ack_in;
            end
         end
      end else begin
         for (int i = cht_pkg::AccDepth - 1; i >= 0; i--)
            if (mdl_acc_v[i])
               hit = i;
         if (hit < 0) begin
            o.status = cht_pkg::ST_EMPTY;
         end else begin
            o.status     = cht_pkg::ST_POPPED;
            o.slot       = hit[2:0];
            o.out_ip     = mdl_acc_ip[hit];
            o.out_port   = mdl_acc_port[hit];
            o.out_handle = mdl_acc_hdl[hit];
            mdl_acc_v[hit] = 1'b0;
         end
      end
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push    <= 1'b0;
         drv_req <= '0;
      end else begin
         if (push && !full) begin
            if (drv_req.op != cht_pkg::OP_NONE)
               expected_rsps.push_back(predict_response(drv_req));
            n_req = n_req + 1;
         end
         if (!push || !full) begin
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               drv_req <= pending_reqs.pop_front();
               push    <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response status %0d", $time, dut_rsp.status);
               errors = errors + 1;
            end else begin
               cht_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e !== dut_rsp) begin
                  $display("%0t: mismatch expected %h actual %h", $time, e, dut_rsp);
                  errors = errors + 1;
               end
               status_seen[e.status] = status_seen[e.status] + 1;
            end
            n_rsp = n_rsp + 1;
         end
         pop <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   function automatic cht_pkg::req_type make_req(logic [1:0] op, int peer);
      cht_pkg::req_type r;
      r.op          = op;
      r.peer_ip     = pool_ip[peer];
      r.peer_port   = pool_port[peer];
      r.conn_handle = 16'($urandom);
      r.local_port  = 16'($urandom);
      r.seq_in      = $urandom;
      r.ack_in      = $urandom;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_iss(logic [31:0] v);
      csr_initial_seq <= v;
      csr_valid       <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mdl_iss = v;
      csr_valid <= 1'b0;
   endtask

   task automatic fill_random(int count);
      int               k;
      cht_pkg::req_type r;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99, 0);
         if (k < 3) begin
            r = '0;
            r.op          = 2'($urandom);
            r.peer_ip     = $urandom;
            r.peer_port   = 16'($urandom);
            r.conn_handle = 16'($urandom);
            r.local_port  = 16'($urandom);
            r.seq_in      = $urandom;
            r.ack_in      = $urandom;
         end else if (k < 45) begin
            r = make_req(cht_pkg::OP_SYN, $urandom_range(5, 0));
         end else if (k < 80) begin
            r = make_req(cht_pkg::OP_ACK, $urandom_range(5, 0));
         end else begin
            r = make_req(cht_pkg::OP_ACCEPT, 0);
         end
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      cht_pkg::req_type r;
      errors = 0;
      n_req  = 0;
      n_rsp  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (mdl_pend_v[i]) mdl_pend_v[i] = 1'b0;
      foreach (mdl_acc_v[i]) mdl_acc_v[i] = 1'b0;
      mdl_last_ack    = '0;
      mdl_last_port   = '0;
      mdl_iss         = '0;
      send_idle_pct   = 15;
      recv_idle_pct   = 88;
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_initial_seq = '0;
      pool_ip[0] = 32'h0; pool_port[0] = 16'h0;
      pool_ip[1] = 32'hFFFF_FFFF; pool_port[1] = 16'hFFFF;
      pool_ip[2] = 32'hFFFF_FFFF; pool_port[2] = 16'h0;
      for (int i = 3; i < 6; i++) begin
         pool_ip[i]   = $urandom;
         pool_port[i] = 16'($urandom);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty accept, ack with nothing pending, fill to drop, resend
      pending_reqs.push_back(make_req(cht_pkg::OP_ACCEPT, 0));
      pending_reqs.push_back(make_req(cht_pkg::OP_ACK, 1));
      r = make_req(cht_pkg::OP_SYN, 1);
      r.seq_in = 32'hFFFF_FFFF;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(cht_pkg::OP_SYN, 1));
      for (int i = 0; i < 7; i++) begin
         r = make_req(cht_pkg::OP_SYN, 0);
         r.peer_ip = 32'h1000 + i;
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(cht_pkg::OP_SYN, 2));
      r = make_req(cht_pkg::OP_ACK, 1);
      r.seq_in = 32'hFFFF_FFFF;
      r.ack_in = 32'hFFFF_FFFF;
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(cht_pkg::OP_ACK, 1));
      for (int i = 0; i < 7; i++) begin
         r = make_req(cht_pkg::OP_ACK, 0);
         r.peer_ip = 32'h1000 + i;
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(cht_pkg::OP_ACK, 2));
      r = make_req(cht_pkg::OP_NONE, 3);
      pending_reqs.push_back(r);
      pending_reqs.push_back(make_req(cht_pkg::OP_ACCEPT, 0));
      wait_drained();

      write_iss(32'hFFFF_FFFF);
      fill_random(400);
      wait_drained();
      write_iss(32'h0);
      send_idle_pct = 88;
      recv_idle_pct = 15;
      fill_random(400);
      wait_drained();
      write_iss($urandom);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_random(420);
      wait_drained();

      $display("requests %0d responses %0d; synack %0d resend %0d dropped %0d estab %0d",
               n_req, n_rsp, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("already %0d accfull %0d nopend %0d popped %0d empty %0d",
               status_seen[4], status_seen[5], status_seen[6], status_seen[7],
               status_seen[8]);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("connection_handshake_table verification clean");
      else
         $display("connection_handshake_table verification failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("connection_handshake_table verification failed");
      $finish;
   end

endmodule
